// File: rtl/core/rrbm_pkg.sv
package rrbm_pkg;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [2:0] KIND_ROM    = 3'd0;
    localparam logic [2:0] KIND_RAM_RD = 3'd1;
    localparam logic [2:0] KIND_RAM_WR = 3'd2;
    localparam logic [2:0] KIND_CLOCK  = 3'd3;
    localparam logic [2:0] KIND_OPEN   = 3'd4;
    localparam logic [2:0] KIND_NONE   = 3'd5;

    localparam logic [1:0] CFG_ROM_COUNT = 2'd0;
    localparam logic [1:0] CFG_RAM_COUNT = 2'd1;
    localparam logic [1:0] CFG_HAS_CLOCK = 2'd2;

    localparam logic [7:0] RTC_SEC  = 8'h08;
    localparam logic [7:0] RTC_MIN  = 8'h09;
    localparam logic [7:0] RTC_HOUR = 8'h0A;
    localparam logic [7:0] RTC_DAYL = 8'h0B;
    localparam logic [7:0] RTC_DAYH = 8'h0C;

    localparam logic [7:0] RAM_ENABLE_KEY = 8'h0A;
    localparam logic [7:0] LATCH_ARM      = 8'h00;
    localparam logic [7:0] LATCH_FIRE     = 8'h01;
    localparam logic [7:0] OPEN_BUS       = 8'hFF;
    localparam logic [7:0] MAX_ROM_BANKS  = 8'd128;
    localparam logic [7:0] ROM_COUNT_RST  = 8'd2;

    localparam logic [5:0] SEC_LAST  = 6'd59;
    localparam logic [4:0] HOUR_LAST = 5'd23;
    localparam logic [8:0] DAY_LAST  = 9'd511;

    // Remainder unit handles two dividend bits per cycle over an 8-bit dividend.
    localparam logic [1:0] DIV_LAST_STEP = 2'd3;

    localparam int IN_W  = 32;
    localparam int OUT_W = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic out_busy;
    } t_sts;

endpackage

// File: rtl/core/rrbm_ctrl.sv
module rrbm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rrbm_pkg::t_sts i_sts,
    output rrbm_pkg::t_cmd o_cmd
);

    rrbm_pkg::t_state r_state, n_state;
    logic [1:0]       r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrbm_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            rrbm_pkg::ST_IDLE: begin
                n_step = '0;
                if (i_in_valid) begin
                    n_state = i_sts.need_div ? rrbm_pkg::ST_DIV : rrbm_pkg::ST_DONE;
                end
            end
            rrbm_pkg::ST_DIV: begin
                n_step = r_step + 2'd1;
                if (r_step == rrbm_pkg::DIV_LAST_STEP) begin
                    n_state = rrbm_pkg::ST_DONE;
                end
            end
            rrbm_pkg::ST_DONE: begin
                if (!i_sts.out_busy) begin
                    n_state = rrbm_pkg::ST_IDLE;
                end
            end
            default: n_state = rrbm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.div_step = 1'b0;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            rrbm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            rrbm_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            rrbm_pkg::ST_DONE: begin
                o_cmd.out_load = !i_sts.out_busy;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrbm_pkg::ST_DIV && r_step == rrbm_pkg::DIV_LAST_STEP)
        |=> r_state == rrbm_pkg::ST_DONE)
        else $error("remainder unit did not finish after its last step");

    a_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrbm_pkg::ST_IDLE) |=> (r_step == 2'd0))
        else $error("step counter not cleared on leaving idle");

endmodule

// File: rtl/core/rrbm_dp.sv
module rrbm_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [1:0]                 i_cfg_index,
    input  logic [7:0]                 i_cfg_data,
    input  logic [rrbm_pkg::IN_W-1:0]  i_in_data,
    output logic [rrbm_pkg::OUT_W-1:0] o_out_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    input  rrbm_pkg::t_cmd             i_cmd,
    output rrbm_pkg::t_sts             o_sts
);

    logic [1:0]  w_op;
    logic [15:0] w_addr;
    logic [7:0]  w_wdata;

    assign w_op    = i_in_data[1:0];
    assign w_addr  = i_in_data[17:2];
    assign w_wdata = i_in_data[25:18];

    logic [7:0] r_rom_count;
    logic [3:0] r_ram_count;
    logic       r_has_clock;

    logic       r_ram_en,   n_ram_en;
    logic [6:0] r_rom_sel,  n_rom_sel;
    logic [7:0] r_ram_sel,  n_ram_sel;
    logic [7:0] r_prev_lat, n_prev_lat;

    logic [5:0] r_sec,  n_sec,  r_lsec,  n_lsec;
    logic [5:0] r_min,  n_min,  r_lmin,  n_lmin;
    logic [4:0] r_hour, n_hour, r_lhour, n_lhour;
    logic [8:0] r_day,  n_day,  r_lday,  n_lday;
    logic       r_cry,  n_cry,  r_lcry,  n_lcry;

    logic [2:0]  r_kind,  n_kind;
    logic [20:0] r_maddr, n_maddr;
    logic [7:0]  r_rdata, n_rdata;
    logic        r_need_div;

    logic [7:0] r_rem, r_dividend, r_div_m;
    logic [7:0] w_rem1, w_rem2;

    logic        r_out_valid;
    logic [2:0]  r_out_kind;
    logic [20:0] r_out_addr;
    logic [7:0]  r_out_rdata;

    logic       w_ram_hit;
    logic       w_clk_hit;
    logic       w_upper_rom;
    logic [7:0] w_lat_byte;
    logic [7:0] w_m;

    assign w_upper_rom = (w_op == rrbm_pkg::OP_READ) && (w_addr[15:14] == 2'b01);
    assign w_ram_hit   = r_ram_sel < {4'd0, r_ram_count};
    assign w_clk_hit   = r_has_clock && (r_ram_sel >= rrbm_pkg::RTC_SEC)
                         && (r_ram_sel <= rrbm_pkg::RTC_DAYH);
    assign w_m         = (r_rom_count > rrbm_pkg::MAX_ROM_BANKS) ?
                         rrbm_pkg::MAX_ROM_BANKS : r_rom_count;

    assign o_sts.need_div = w_upper_rom;
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    always_comb begin
        case (r_ram_sel)
            rrbm_pkg::RTC_SEC:  w_lat_byte = {2'd0, r_lsec};
            rrbm_pkg::RTC_MIN:  w_lat_byte = {2'd0, r_lmin};
            rrbm_pkg::RTC_HOUR: w_lat_byte = {3'd0, r_lhour};
            rrbm_pkg::RTC_DAYL: w_lat_byte = r_lday[7:0];
            rrbm_pkg::RTC_DAYH: w_lat_byte = {r_lcry, 6'd0, r_lday[8]};
            default:            w_lat_byte = 8'd0;
        endcase
    end

    always_comb begin
        n_ram_en   = r_ram_en;
        n_rom_sel  = r_rom_sel;
        n_ram_sel  = r_ram_sel;
        n_prev_lat = r_prev_lat;
        n_sec  = r_sec;  n_min  = r_min;  n_hour  = r_hour;
        n_day  = r_day;  n_cry  = r_cry;
        n_lsec = r_lsec; n_lmin = r_lmin; n_lhour = r_lhour;
        n_lday = r_lday; n_lcry = r_lcry;
        n_kind  = rrbm_pkg::KIND_NONE;
        n_maddr = '0;
        n_rdata = '0;
        case (w_op)
            rrbm_pkg::OP_TICK: begin
                if (r_has_clock) begin
                    if (r_sec != rrbm_pkg::SEC_LAST) begin
                        n_sec = r_sec + 6'd1;
                    end else begin
                        n_sec = '0;
                        if (r_min != rrbm_pkg::SEC_LAST) begin
                            n_min = r_min + 6'd1;
                        end else begin
                            n_min = '0;
                            if (r_hour != rrbm_pkg::HOUR_LAST) begin
                                n_hour = r_hour + 5'd1;
                            end else begin
                                n_hour = '0;
                                if (r_day == rrbm_pkg::DAY_LAST) begin
                                    n_day = '0;
                                    n_cry = 1'b1;
                                end else begin
                                    n_day = r_day + 9'd1;
                                end
                            end
                        end
                    end
                end
            end
            rrbm_pkg::OP_READ: begin
                if (w_addr[15] == 1'b0) begin
                    n_kind  = rrbm_pkg::KIND_ROM;
                    n_maddr = {7'd0, w_addr[13:0]};
                end else begin
                    n_kind  = rrbm_pkg::KIND_OPEN;
                    n_rdata = rrbm_pkg::OPEN_BUS;
                    if (w_addr[15:13] == 3'b101 && r_ram_en) begin
                        if (w_ram_hit) begin
                            n_kind  = rrbm_pkg::KIND_RAM_RD;
                            n_rdata = '0;
                            n_maddr = {4'd0, r_ram_sel[3:0], w_addr[12:0]};
                        end else if (w_clk_hit) begin
                            n_kind  = rrbm_pkg::KIND_CLOCK;
                            n_rdata = w_lat_byte;
                        end
                    end
                end
            end
            rrbm_pkg::OP_WRITE: begin
                case (w_addr[15:13])
                    3'b000: n_ram_en = (w_wdata == rrbm_pkg::RAM_ENABLE_KEY);
                    3'b001: n_rom_sel = (w_wdata[6:0] == 7'd0) ? 7'd1 : w_wdata[6:0];
                    3'b010: n_ram_sel = w_wdata;
                    3'b011: begin
                        if (r_has_clock) begin
                            if (r_prev_lat == rrbm_pkg::LATCH_ARM
                                && w_wdata == rrbm_pkg::LATCH_FIRE) begin
                                n_lsec  = r_sec;
                                n_lmin  = r_min;
                                n_lhour = r_hour;
                                n_lday  = r_day;
                                n_lcry  = r_cry;
                            end
                            n_prev_lat = w_wdata;
                        end
                    end
                    3'b101: begin
                        if (r_ram_en) begin
                            if (w_ram_hit) begin
                                n_kind  = rrbm_pkg::KIND_RAM_WR;
                                n_maddr = {4'd0, r_ram_sel[3:0], w_addr[12:0]};
                            end else if (w_clk_hit) begin
                                n_kind = rrbm_pkg::KIND_CLOCK;
                                case (r_ram_sel)
                                    rrbm_pkg::RTC_SEC: begin
                                        n_sec   = w_wdata[5:0];
                                        n_rdata = {2'd0, w_wdata[5:0]};
                                    end
                                    rrbm_pkg::RTC_MIN: begin
                                        n_min   = w_wdata[5:0];
                                        n_rdata = {2'd0, w_wdata[5:0]};
                                    end
                                    rrbm_pkg::RTC_HOUR: begin
                                        n_hour  = w_wdata[4:0];
                                        n_rdata = {3'd0, w_wdata[4:0]};
                                    end
                                    rrbm_pkg::RTC_DAYL: begin
                                        n_day   = {r_day[8], w_wdata};
                                        n_rdata = w_wdata;
                                    end
                                    default: begin
                                        n_day   = {w_wdata[0], r_day[7:0]};
                                        n_cry   = w_wdata[7];
                                        n_rdata = {w_wdata[7], 6'd0, w_wdata[0]};
                                    end
                                endcase
                            end
                        end
                    end
                    default: n_kind = rrbm_pkg::KIND_NONE;
                endcase
            end
            default: n_kind = rrbm_pkg::KIND_NONE;
        endcase
    end

    always_comb begin
        w_rem1 = {r_rem[6:0], r_dividend[7]};
        if (w_rem1 >= r_div_m) begin
            w_rem1 = w_rem1 - r_div_m;
        end
        w_rem2 = {w_rem1[6:0], r_dividend[6]};
        if (w_rem2 >= r_div_m) begin
            w_rem2 = w_rem2 - r_div_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_count <= rrbm_pkg::ROM_COUNT_RST;
            r_ram_count <= '0;
            r_has_clock <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rrbm_pkg::CFG_ROM_COUNT: r_rom_count <= i_cfg_data;
                rrbm_pkg::CFG_RAM_COUNT: r_ram_count <= i_cfg_data[3:0];
                rrbm_pkg::CFG_HAS_CLOCK: r_has_clock <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_en   <= 1'b0;
            r_rom_sel  <= 7'd1;
            r_ram_sel  <= '0;
            r_prev_lat <= '0;
            r_sec  <= '0; r_min  <= '0; r_hour  <= '0; r_day  <= '0; r_cry  <= 1'b0;
            r_lsec <= '0; r_lmin <= '0; r_lhour <= '0; r_lday <= '0; r_lcry <= 1'b0;
        end else if (i_cmd.load) begin
            r_ram_en   <= n_ram_en;
            r_rom_sel  <= n_rom_sel;
            r_ram_sel  <= n_ram_sel;
            r_prev_lat <= n_prev_lat;
            r_sec  <= n_sec;  r_min  <= n_min;  r_hour  <= n_hour;
            r_day  <= n_day;  r_cry  <= n_cry;
            r_lsec <= n_lsec; r_lmin <= n_lmin; r_lhour <= n_lhour;
            r_lday <= n_lday; r_lcry <= n_lcry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind     <= n_kind;
            r_maddr    <= n_maddr;
            r_rdata    <= n_rdata;
            r_need_div <= w_upper_rom;
            r_rem      <= '0;
            r_dividend <= {1'b0, r_rom_sel};
            r_div_m    <= w_m;
        end else if (i_cmd.div_step) begin
            r_rem      <= w_rem2;
            r_dividend <= {r_dividend[5:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_kind  <= r_kind;
            r_out_addr  <= r_need_div ? {r_rem[6:0], r_maddr[13:0]} : r_maddr;
            r_out_rdata <= r_rdata;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {r_out_rdata, r_out_addr, r_out_kind};

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_out_valid && !i_out_ready))
        else $error("result register overwritten while a beat is pending");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && r_need_div && r_div_m != 8'd0) |-> (r_rem < r_div_m))
        else $error("bank remainder not below the bank count");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_kind <= rrbm_pkg::KIND_NONE))
        else $error("result kind out of range");

endmodule

// File: rtl/core/rom_ram_bank_mapper_with_rtc.sv
// Each input beat is registered; then, for reads of the switchable ROM window,
// the bank remainder unit runs four steps before the result register is loaded.
// One beat is handled at a time, and a stalled output holds it in the done state;
// the next input beat is taken while the previous result still waits at the output.
// Reset (i_rst_n low, synchronous) restores bank 1, RAM disabled, clock counters zero.
module rom_ram_bank_mapper_with_rtc (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // bus_address[15:0], write_data[23:16]
    input  logic [23:0] s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // memory_address[20:0], read_data[28:21], zero fill[31:29]
    output logic [31:0] m_axis_tdata,
    // access_kind[2:0]
    output logic [2:0]  m_axis_tuser
);

    rrbm_pkg::t_cmd w_cmd;
    rrbm_pkg::t_sts w_sts;

    logic [rrbm_pkg::IN_W-1:0]  w_in_data;
    logic [rrbm_pkg::OUT_W-1:0] w_out_data;

    assign o_cfg_ready = 1'b1;

    assign w_in_data    = {6'd0, s_axis_tdata, s_axis_tuser};
    assign m_axis_tuser = w_out_data[2:0];
    assign m_axis_tdata = {3'd0, w_out_data[31:3]};

    rrbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rrbm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (w_in_data),
        .o_out_data  (w_out_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

// File: tb/tb.sv
module tb;

    localparam int ROM_BANK_BYTES = 16384;
    localparam int RAM_BANK_BYTES = 8192;
    localparam int RANDOM_ITEMS   = 1250;
    localparam int PHASES         = 6;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int LONG_HOLD      = 400;
    localparam int LONG_HOLD_AT   = 500;

    localparam logic [15:0] ENABLE_END     = 16'h1FFF;
    localparam logic [15:0] ROM_FIXED_END  = 16'h3FFF;
    localparam logic [15:0] ROM_WINDOW     = 16'h4000;
    localparam logic [15:0] RAM_SEL_END    = 16'h5FFF;
    localparam logic [15:0] LATCH_LO       = 16'h6000;
    localparam logic [15:0] ROM_SWITCH_END = 16'h7FFF;
    localparam logic [15:0] EXT_RAM_LO     = 16'hA000;
    localparam logic [15:0] EXT_RAM_HI     = 16'hBFFF;

    localparam logic [4:0][7:0] RTC_MASK = {8'h81, 8'hFF, 8'h1F, 8'h3F, 8'h3F};
    localparam logic [4:0][7:0] RTC_ROLL = {8'h01, 8'hFF, 8'(rrbm_pkg::HOUR_LAST),
                                            8'(rrbm_pkg::SEC_LAST),
                                            8'(rrbm_pkg::SEC_LAST)};

    typedef struct packed {
        logic [2:0]  kind;
        logic [20:0] maddr;
        logic [7:0]  rdata;
    } t_bus_reply;

    // A row either writes a register (code is the index) or sends one access
    // (code is the opcode); typed rows carry the reply expected at a glance.
    typedef struct packed {
        bit          is_cfg;
        logic [1:0]  code;
        logic [15:0] addr;
        logic [7:0]  data;
        bit          typed;
        t_bus_reply  want;
    } t_script_row;

    localparam t_bus_reply NONE_REPLY = '{rrbm_pkg::KIND_NONE, 21'd0, 8'h00};
    localparam t_bus_reply OPEN_REPLY = '{rrbm_pkg::KIND_OPEN, 21'd0, rrbm_pkg::OPEN_BUS};
    localparam t_bus_reply NO_WANT    = '0;

    localparam int SCRIPT_LEN = 30;
    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        {1'b0, rrbm_pkg::OP_READ,  16'h0000, 8'h00, 1'b1, rrbm_pkg::KIND_ROM, 21'h000000, 8'h00},
        {1'b0, rrbm_pkg::OP_READ,  16'h3FFF, 8'h00, 1'b1, rrbm_pkg::KIND_ROM, 21'h003FFF, 8'h00},
        {1'b0, rrbm_pkg::OP_READ,  16'h4000, 8'h00, 1'b1, rrbm_pkg::KIND_ROM, 21'h004000, 8'h00},
        {1'b0, rrbm_pkg::OP_READ,  16'hA000, 8'h00, 1'b1, OPEN_REPLY},
        {1'b0, rrbm_pkg::OP_READ,  16'hFFFF, 8'hFF, 1'b1, OPEN_REPLY},
        {1'b0, rrbm_pkg::OP_WRITE, 16'h2000, 8'h00, 1'b1, NONE_REPLY},
        {1'b0, rrbm_pkg::OP_READ,  16'h4000, 8'h00, 1'b0, NO_WANT},
        {1'b0, rrbm_pkg::OP_WRITE, 16'h3FFF, 8'hFF, 1'b1, NONE_REPLY},
        {1'b0, rrbm_pkg::OP_READ,  16'h5000, 8'h00, 1'b0, NO_WANT},
        {1'b0, rrbm_pkg::OP_WRITE, 16'h0000, rrbm_pkg::RAM_ENABLE_KEY, 1'b1, NONE_REPLY},
        {1'b0, rrbm_pkg::OP_READ,  16'hBFFF, 8'h00, 1'b0, NO_WANT},
        {1'b0, rrbm_pkg::OP_WRITE, 16'hA000, 8'h55, 1'b0, NO_WANT},
        {1'b0, rrbm_pkg::OP_TICK,  16'hFFFF, 8'hFF, 1'b1, NONE_REPLY},
        {1'b0, rrbm_pkg::OP_NOP,   16'hFFFF, 8'hFF, 1'b1, NONE_REPLY},
        {1'b1, rrbm_pkg::CFG_ROM_COUNT, 16'h0000, rrbm_pkg::MAX_ROM_BANKS, 1'b0, NO_WANT},
        {1'b1, rrbm_pkg::CFG_RAM_COUNT, 16'h0000, 8'd8, 1'b0, NO_WANT},
        {1'b1, rrbm_pkg::CFG_HAS_CLOCK, 16'h0000, 8'd1, 1'b0, NO_WANT},
        {1'b0, rrbm_pkg::OP_WRITE, 16'h5FFF, 8'h07, 1'b1, NONE_REPLY},
        {1'b0, rrbm_pkg::OP_READ,  16'hBFFF, 8'h00, 1'b0, NO_WANT},
        {1'b0, rrbm_pkg::OP_WRITE, 16'hA123, 8'hAA, 1'b0, NO_WANT},
        {1'b0, rrbm_pkg::OP_WRITE, 16'h4000, rrbm_pkg::RTC_SEC, 1'b1, NONE_REPLY},
        {1'b0, rrbm_pkg::OP_WRITE, 16'hA000, 8'hFF, 1'b0, NO_WANT},
        {1'b0, rrbm_pkg::OP_WRITE, 16'h4000, rrbm_pkg::RTC_DAYH, 1'b1, NONE_REPLY},
        {1'b0, rrbm_pkg::OP_WRITE, 16'hBFFF, 8'hFF, 1'b0, NO_WANT},
        {1'b0, rrbm_pkg::OP_TICK,  16'h0000, 8'h00, 1'b1, NONE_REPLY},
        {1'b0, rrbm_pkg::OP_WRITE, 16'h6000, rrbm_pkg::LATCH_ARM, 1'b1, NONE_REPLY},
        {1'b0, rrbm_pkg::OP_WRITE, 16'h7FFF, rrbm_pkg::LATCH_FIRE, 1'b1, NONE_REPLY},
        {1'b0, rrbm_pkg::OP_READ,  16'hA000, 8'h00, 1'b0, NO_WANT},
        {1'b0, rrbm_pkg::OP_WRITE, 16'h1FFF, 8'h0B, 1'b1, NONE_REPLY},
        {1'b0, rrbm_pkg::OP_READ,  16'hA000, 8'h00, 1'b1, OPEN_REPLY}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // bus_address[15:0], write_data[23:16]
    logic [23:0] s_axis_tdata = '0;
    // opcode[1:0]
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // memory_address[20:0], read_data[28:21], zero fill[31:29]
    logic [31:0] m_axis_tdata;
    // access_kind[2:0]
    logic [2:0]  m_axis_tuser;

    rom_ram_bank_mapper_with_rtc u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    logic [7:0]      rom_banks = rrbm_pkg::ROM_COUNT_RST;
    logic [3:0]      ram_banks = '0;
    logic            clk_fitted = 1'b0;
    logic            ram_on = 1'b0;
    logic [6:0]      rom_sel = 7'd1;
    logic [7:0]      ram_sel = '0;
    logic [7:0]      last_latch = '0;
    logic [4:0][7:0] rtc_live = '0;
    logic [4:0][7:0] rtc_held = '0;

    t_bus_reply mapped_q[$];
    int         mismatches = 0;
    int         sent = 0;
    int         beats_seen = 0;
    int         cycle_count = 0;
    bit         calm = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic int rtc_slot();
        if (!clk_fitted || ram_sel < rrbm_pkg::RTC_SEC || ram_sel > rrbm_pkg::RTC_DAYH) begin
            return -1;
        end
        return int'(ram_sel - rrbm_pkg::RTC_SEC);
    endfunction

    function automatic t_bus_reply map_access(input logic [1:0] op, input logic [15:0] addr,
                                              input logic [7:0] data);
        t_bus_reply r;
        int         slot;
        int         banks;
        int         bank;
        logic [8:0] day;
        r = NONE_REPLY;
        case (op)
            rrbm_pkg::OP_TICK: begin
                if (clk_fitted) begin
                    if (rtc_live[0] == 8'(rrbm_pkg::SEC_LAST)) begin
                        rtc_live[0] = '0;
                        if (rtc_live[1] == 8'(rrbm_pkg::SEC_LAST)) begin
                            rtc_live[1] = '0;
                            if (rtc_live[2] == 8'(rrbm_pkg::HOUR_LAST)) begin
                                rtc_live[2] = '0;
                                day = {rtc_live[4][0], rtc_live[3]};
                                if (day == rrbm_pkg::DAY_LAST) begin
                                    rtc_live[4][7] = 1'b1;
                                end
                                day = day + 9'd1;
                                rtc_live[3] = day[7:0];
                                rtc_live[4] = {rtc_live[4][7], 6'b0, day[8]};
                            end else begin
                                rtc_live[2] = (rtc_live[2] + 8'd1) & RTC_MASK[2];
                            end
                        end else begin
                            rtc_live[1] = (rtc_live[1] + 8'd1) & RTC_MASK[1];
                        end
                    end else begin
                        rtc_live[0] = (rtc_live[0] + 8'd1) & RTC_MASK[0];
                    end
                end
            end
            rrbm_pkg::OP_READ: begin
                if (addr <= ROM_FIXED_END) begin
                    r = '{rrbm_pkg::KIND_ROM, 21'(addr), 8'h00};
                end else if (addr <= ROM_SWITCH_END) begin
                    banks = (rom_banks > rrbm_pkg::MAX_ROM_BANKS)
                            ? int'(rrbm_pkg::MAX_ROM_BANKS) : int'(rom_banks);
                    bank = int'(rom_sel);
                    if (banks != 0) begin
                        bank = bank % banks;
                    end
                    r = '{rrbm_pkg::KIND_ROM,
                          21'(bank * ROM_BANK_BYTES + int'(addr - ROM_WINDOW)), 8'h00};
                end else begin
                    r = OPEN_REPLY;
                    if (addr >= EXT_RAM_LO && addr <= EXT_RAM_HI && ram_on) begin
                        slot = rtc_slot();
                        if (ram_sel < ram_banks) begin
                            r = '{rrbm_pkg::KIND_RAM_RD, 21'(int'(ram_sel) * RAM_BANK_BYTES
                                                  + int'(addr - EXT_RAM_LO)), 8'h00};
                        end else if (slot >= 0) begin
                            r = '{rrbm_pkg::KIND_CLOCK, 21'd0, rtc_held[slot]};
                        end
                    end
                end
            end
            rrbm_pkg::OP_WRITE: begin
                if (addr <= ENABLE_END) begin
                    ram_on = (data == rrbm_pkg::RAM_ENABLE_KEY);
                end else if (addr <= ROM_FIXED_END) begin
                    rom_sel = (data[6:0] == 7'd0) ? 7'd1 : data[6:0];
                end else if (addr <= RAM_SEL_END) begin
                    ram_sel = data;
                end else if (addr <= ROM_SWITCH_END) begin
                    if (clk_fitted) begin
                        if (last_latch == rrbm_pkg::LATCH_ARM
                                && data == rrbm_pkg::LATCH_FIRE) begin
                            rtc_held = rtc_live;
                        end
                        last_latch = data;
                    end
                end else if (addr >= EXT_RAM_LO && addr <= EXT_RAM_HI && ram_on) begin
                    slot = rtc_slot();
                    if (ram_sel < ram_banks) begin
                        r = '{rrbm_pkg::KIND_RAM_WR, 21'(int'(ram_sel) * RAM_BANK_BYTES
                                              + int'(addr - EXT_RAM_LO)), 8'h00};
                    end else if (slot >= 0) begin
                        rtc_live[slot] = data & RTC_MASK[slot];
                        r = '{rrbm_pkg::KIND_CLOCK, 21'd0, rtc_live[slot]};
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic issue_access(input logic [1:0] op, input logic [15:0] addr,
                                input logic [7:0] data, input bit typed,
                                input t_bus_reply want);
        t_bus_reply got;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {data, addr};
        do @(posedge i_clk); while (!s_axis_tready);
        got = map_access(op, addr, data);
        mapped_q.push_back(typed ? want : got);
        sent++;
    endtask

    task automatic settle(input int tail);
        s_axis_tvalid <= 1'b0;
        while (mapped_q.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] index, input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            rrbm_pkg::CFG_ROM_COUNT: rom_banks = value;
            rrbm_pkg::CFG_RAM_COUNT: ram_banks = value[3:0];
            rrbm_pkg::CFG_HAS_CLOCK: clk_fitted = value[0];
            default: begin
            end
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic play_scene();
        int         pick;
        int         n;
        logic [7:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            case ($urandom_range(0, 2))
                0: v = 8'h00;
                1: v = 8'h80;
                default: v = 8'($urandom);
            endcase
            issue_access(rrbm_pkg::OP_WRITE, 16'($urandom_range(16'h2000, 16'h3FFF)), v,
                         1'b0, NO_WANT);
            n = $urandom_range(1, 4);
            repeat (n) begin
                issue_access(rrbm_pkg::OP_READ, 16'($urandom_range(0, 16'h7FFF)),
                             8'($urandom), 1'b0, NO_WANT);
            end
        end else if (pick < 45) begin
            v = ($urandom_range(0, 3) != 0) ? rrbm_pkg::RAM_ENABLE_KEY : 8'($urandom);
            issue_access(rrbm_pkg::OP_WRITE, 16'($urandom_range(0, ENABLE_END)), v,
                         1'b0, NO_WANT);
            v = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 9)) : 8'($urandom);
            issue_access(rrbm_pkg::OP_WRITE, 16'($urandom_range(ROM_WINDOW, RAM_SEL_END)), v,
                         1'b0, NO_WANT);
            n = $urandom_range(2, 6);
            repeat (n) begin
                issue_access($urandom_range(0, 1) ? rrbm_pkg::OP_WRITE : rrbm_pkg::OP_READ,
                             16'($urandom_range(EXT_RAM_LO, EXT_RAM_HI)), 8'($urandom),
                             1'b0, NO_WANT);
            end
        end else if (pick < 75) begin
            issue_access(rrbm_pkg::OP_WRITE, 16'($urandom_range(0, ENABLE_END)),
                         rrbm_pkg::RAM_ENABLE_KEY, 1'b0, NO_WANT);
            for (int i = 0; i < 5; i++) begin
                issue_access(rrbm_pkg::OP_WRITE, 16'($urandom_range(ROM_WINDOW, RAM_SEL_END)),
                             8'(rrbm_pkg::RTC_SEC + i), 1'b0, NO_WANT);
                v = $urandom_range(0, 1) ? RTC_ROLL[i] : 8'($urandom);
                issue_access(rrbm_pkg::OP_WRITE, 16'($urandom_range(EXT_RAM_LO, EXT_RAM_HI)),
                             v, 1'b0, NO_WANT);
            end
            n = $urandom_range(1, 3);
            repeat (n) begin
                issue_access(rrbm_pkg::OP_TICK, 16'($urandom), 8'($urandom), 1'b0, NO_WANT);
            end
            v = ($urandom_range(0, 7) != 0) ? rrbm_pkg::LATCH_ARM : 8'($urandom);
            issue_access(rrbm_pkg::OP_WRITE, 16'($urandom_range(LATCH_LO, ROM_SWITCH_END)), v,
                         1'b0, NO_WANT);
            issue_access(rrbm_pkg::OP_WRITE, 16'($urandom_range(LATCH_LO, ROM_SWITCH_END)),
                         rrbm_pkg::LATCH_FIRE, 1'b0, NO_WANT);
            for (int i = 0; i < 5; i++) begin
                issue_access(rrbm_pkg::OP_WRITE, 16'($urandom_range(ROM_WINDOW, RAM_SEL_END)),
                             8'(rrbm_pkg::RTC_SEC + i), 1'b0, NO_WANT);
                issue_access(rrbm_pkg::OP_READ, 16'($urandom_range(EXT_RAM_LO, EXT_RAM_HI)),
                             8'($urandom), 1'b0, NO_WANT);
            end
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) begin
                issue_access(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom),
                             1'b0, NO_WANT);
            end
        end
    endtask

    initial begin : result_sink
        int         hold_left;
        bit         long_hold_done;
        t_bus_reply seen;
        t_bus_reply want;
        hold_left = 0;
        long_hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                seen.kind  = m_axis_tuser;
                seen.maddr = m_axis_tdata[20:0];
                seen.rdata = m_axis_tdata[28:21];
                beats_seen++;
                if (mapped_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected beat: kind %0d addr %h data %h",
                                 seen.kind, seen.maddr, seen.rdata);
                    end
                end else begin
                    want = mapped_q.pop_front();
                    if (seen.kind !== want.kind || seen.maddr !== want.maddr
                            || seen.rdata !== want.rdata) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp kind %0d addr %h data %h, got %0d %h %h",
                                     want.kind, want.maddr, want.rdata,
                                     seen.kind, seen.maddr, seen.rdata);
                        end
                    end
                end
            end
            if (!i_rst_n) begin
                m_axis_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!long_hold_done && beats_seen >= LONG_HOLD_AT) begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                hold_left = $urandom_range(0, 6);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        t_script_row row;
        logic [7:0]  rom_n;
        logic [7:0]  ram_n;
        logic [7:0]  clk_n;
        int          phase_end;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < SCRIPT_LEN; k++) begin
            row = SCRIPT[k];
            if (row.is_cfg) begin
                settle(8);
                cfg_write(row.code, row.data);
            end else begin
                issue_access(row.code, row.addr, row.data, row.typed, row.want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            settle(8);
            case (p)
                0: begin
                    rom_n = rrbm_pkg::ROM_COUNT_RST;
                    ram_n = 8'd0;
                    clk_n = 8'd1;
                end
                1: begin
                    rom_n = rrbm_pkg::MAX_ROM_BANKS;
                    ram_n = 8'd8;
                    clk_n = 8'd1;
                end
                2: begin
                    rom_n = rrbm_pkg::ROM_COUNT_RST;
                    ram_n = 8'd8;
                    clk_n = 8'd0;
                end
                3: begin
                    rom_n = rrbm_pkg::MAX_ROM_BANKS;
                    ram_n = 8'd0;
                    clk_n = 8'd1;
                end
                default: begin
                    rom_n = 8'($urandom_range(2, 128));
                    ram_n = 8'($urandom_range(0, 8));
                    clk_n = 8'($urandom_range(0, 1));
                end
            endcase
            cfg_write(rrbm_pkg::CFG_ROM_COUNT, rom_n);
            cfg_write(rrbm_pkg::CFG_RAM_COUNT, ram_n);
            cfg_write(rrbm_pkg::CFG_HAS_CLOCK, clk_n);
            calm = (p == PHASES - 1);
            phase_end = sent + RANDOM_ITEMS / PHASES;
            while (sent < phase_end) begin
                play_scene();
            end
        end

        settle(24);
        if (mismatches == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/rrbm_pkg.sv
rtl/core/rrbm_ctrl.sv
rtl/core/rrbm_dp.sv
rtl/core/rom_ram_bank_mapper_with_rtc.sv
tb/tb.sv
